FILE: rtl/tdtr_pkg.sv
package tdtr_pkg;

    // Function codes carried in the func field of an input transaction.
    localparam logic [1:0] FUNC_NODE_WR  = 2'd0;
    localparam logic [1:0] FUNC_VALUE_WR = 2'd1;
    localparam logic [1:0] FUNC_ROUTE    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FIRST_CAT    = 2'd0;
    localparam logic [1:0] CFG_SECOND_CAT   = 2'd1;
    localparam logic [1:0] CFG_FIRST_SLOTS  = 2'd2;
    localparam logic [1:0] CFG_SECOND_SLOTS = 2'd3;

    // 0.5 in Q16.16.
    localparam logic signed [31:0] HALF_Q16 = 32'sh0000_8000;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         node_index;
        logic               is_leaf;
        logic [3:0]         feature_slot;
        logic signed [31:0] threshold;
        logic [7:0]         left_child;
        logic [7:0]         right_child;
        logic [7:0]         missing_child;
        logic [7:0]         leaf_bin;
        logic signed [31:0] feature_value;
        logic               value_invalid;
    } in_item_t;

    typedef struct packed {
        logic [7:0] bin;
        logic       fault;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NODE,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/tdtr_node_ram.sv
module tdtr_node_ram #(
    parameter int WIDTH = 77,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/two_axis_decision_tree_router.sv
// Node writes, value writes and unused function codes are accepted in the idle state
// and leave the block idle. A route transaction walks the tree from node zero; per
// inner node it reads the node memory, then reads the value memory and takes the
// branch decision. The leaf bin or the fault goes to the output register once it is
// free, and no new input is taken before that. A walk faults at its NODE_COUNT-th inner node.
// Reset clears control state and loads the configuration defaults; memories are undefined.
module two_axis_decision_tree_router #(
    parameter int NODE_COUNT  = 256,
    parameter int VALUE_SLOTS = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tdtr_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output tdtr_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [3:0]           cfg_data
);

    // Address widths of the node memory and of the value memory.
    localparam int NAW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int VAW = $clog2(VALUE_SLOTS);
    // Step counter wide enough to hold NODE_COUNT itself.
    localparam int SW  = $clog2(NODE_COUNT + 1);
    // A node entry packs leaf flag, slot, threshold, three links and the bin.
    localparam int NODE_W = 1 + 4 + VALUE_WIDTH + 24 + 8;
    // Saturation bounds of a stored value or threshold.
    localparam longint VMAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - longint'(1);
    localparam longint VMIN = -VMAX - longint'(1);
    // A saturated value can only reach 0.5 when the stored width has room for it.
    localparam bit HALF_FITS = (VALUE_WIDTH > 16);

    // Values and thresholds are clamped to the stored width when it is narrower
    // than the 32-bit port field, and sign extended when it is wider.
    function automatic logic signed [VALUE_WIDTH-1:0] fit_width(input logic signed [31:0] x);
        longint xl;
        xl = longint'(x);
        if (xl > VMAX)
        begin
            return VALUE_WIDTH'(VMAX);
        end
        if (xl < VMIN)
        begin
            return VALUE_WIDTH'(VMIN);
        end
        return VALUE_WIDTH'(xl);
    endfunction

    function automatic logic [NAW-1:0] node_addr(input logic [7:0] idx);
        logic [NAW+7:0] wide;
        wide = {{NAW{1'b0}}, idx};
        return wide[NAW-1:0];
    endfunction

    function automatic logic [VAW-1:0] value_addr(input logic [3:0] slot);
        logic [VAW+3:0] wide;
        wide = {{VAW{1'b0}}, slot};
        return wide[VAW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic       first_cat_reg;
    logic       second_cat_reg;
    logic [3:0] first_slots_reg;
    logic [3:0] second_slots_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_cat_reg    <= 1'b0;
            second_cat_reg   <= 1'b0;
            first_slots_reg  <= 4'd1;
            second_slots_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tdtr_pkg::CFG_FIRST_CAT:    first_cat_reg    <= cfg_data[0];
                tdtr_pkg::CFG_SECOND_CAT:   second_cat_reg   <= cfg_data[0];
                tdtr_pkg::CFG_FIRST_SLOTS:  first_slots_reg  <= cfg_data;
                tdtr_pkg::CFG_SECOND_SLOTS: second_slots_reg <= cfg_data;
                default:                    first_cat_reg    <= first_cat_reg;
            endcase
        end
    end

    // A slot count of zero behaves as one.
    logic [3:0] first_count;
    logic [3:0] second_count;

    assign first_count  = (first_slots_reg == 4'd0) ? 4'd1 : first_slots_reg;
    assign second_count = (second_slots_reg == 4'd0) ? 4'd1 : second_slots_reg;

    // ------------------------------------------------------------------
    // Handshake and control.
    // ------------------------------------------------------------------
    tdtr_pkg::state_t state_reg;
    tdtr_pkg::state_t state_next;

    logic in_accept;
    logic node_wr;
    logic value_wr;
    logic route_start;

    assign in_stall    = (state_reg != tdtr_pkg::ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign node_wr     = in_accept && (in_data.func == tdtr_pkg::FUNC_NODE_WR) &&
                         (32'(in_data.node_index) < NODE_COUNT);
    assign value_wr    = in_accept && (in_data.func == tdtr_pkg::FUNC_VALUE_WR) &&
                         (32'(in_data.feature_slot) < VALUE_SLOTS);
    assign route_start = in_accept && (in_data.func == tdtr_pkg::FUNC_ROUTE);

    // Fields of the node entry held at the node memory output.
    logic                          node_leaf;
    logic [3:0]                    node_slot;
    logic signed [VALUE_WIDTH-1:0] node_thr;
    logic [7:0]                    node_missing;
    logic [7:0]                    node_right;
    logic [7:0]                    node_left;
    logic [7:0]                    node_bin;

    // ------------------------------------------------------------------
    // Value store. The full values live in a memory that is read only at the
    // slot of the node under test. Two flag vectors per slot keep what the
    // missing and categorical tests need: the invalid flag, and whether the
    // slot holds a valid value of at least 0.5. Both are written together
    // with the memory entry.
    // ------------------------------------------------------------------
    logic signed [VALUE_WIDTH-1:0] val_mem [VALUE_SLOTS];
    logic signed [VALUE_WIDTH-1:0] val_rd_reg;
    logic                          val_in_range_reg;
    logic [VALUE_SLOTS-1:0]        inv_vec_reg;
    logic [VALUE_SLOTS-1:0]        half_vec_reg;
    logic                          val_rd;
    logic                          new_half;

    assign new_half = HALF_FITS && !in_data.value_invalid &&
                      (in_data.feature_value >= tdtr_pkg::HALF_Q16);

    always_ff @(posedge clk)
    begin
        if (value_wr)
        begin
            val_mem[value_addr(in_data.feature_slot)]      <= fit_width(in_data.feature_value);
            inv_vec_reg[value_addr(in_data.feature_slot)]  <= in_data.value_invalid;
            half_vec_reg[value_addr(in_data.feature_slot)] <= new_half;
        end
        if (val_rd)
        begin
            val_rd_reg <= val_mem[value_addr(node_slot)];
        end
    end

    // ------------------------------------------------------------------
    // Axis missing tests. Values do not change during a walk, so both axes are
    // evaluated once when the route transaction is accepted and held.
    // ------------------------------------------------------------------
    logic [VALUE_SLOTS-1:0] group0_mask;
    logic [VALUE_SLOTS-1:0] group1_mask;
    logic                   second_start_inv;
    logic                   axis0_missing;
    logic                   axis1_missing;
    logic [1:0]             ax_missing_reg;

    always_comb
    begin
        group0_mask      = '0;
        group1_mask      = '0;
        second_start_inv = 1'b1;
        for (int s = 0; s < VALUE_SLOTS; s++)
        begin
            group0_mask[s] = (s < int'(first_count));
            group1_mask[s] = (s >= int'(first_count)) &&
                             (s < int'(first_count) + int'(second_count));
            if (s == int'(first_count))
            begin
                second_start_inv = inv_vec_reg[s];
            end
        end
    end

    // A continuous axis is missing when its first slot is flagged invalid; a
    // slot beyond the store counts as a valid zero, but the second axis start
    // beyond the store is treated as not valid and so missing.
    assign axis0_missing = first_cat_reg ? ~|(half_vec_reg & group0_mask) : inv_vec_reg[0];
    assign axis1_missing = second_cat_reg ? ~|(half_vec_reg & group1_mask) : second_start_inv;

    // ------------------------------------------------------------------
    // Node memory.
    // ------------------------------------------------------------------
    logic              node_re;
    logic [NAW-1:0]    node_raddr;
    logic [NODE_W-1:0] node_wdata;
    logic [NODE_W-1:0] node_rdata;

    assign node_wdata = {in_data.is_leaf, in_data.feature_slot, fit_width(in_data.threshold),
                         in_data.missing_child, in_data.right_child, in_data.left_child,
                         in_data.leaf_bin};

    tdtr_node_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT),
        .AW    (NAW)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_wr),
        .waddr (node_addr(in_data.node_index)),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    assign {node_leaf, node_slot, node_thr, node_missing, node_right, node_left, node_bin} =
        node_rdata;

    // ------------------------------------------------------------------
    // Branch decision for the node currently held at the memory output.
    // ------------------------------------------------------------------
    logic                          node_axis;
    logic                          node_cat;
    logic                          node_ax_missing;
    logic                          slot_half;
    logic signed [VALUE_WIDTH-1:0] slot_value;
    logic                          go_right;
    logic [7:0]                    next_idx;
    logic                          next_in_range;

    always_comb
    begin
        slot_half = 1'b0;
        for (int s = 0; s < VALUE_SLOTS; s++)
        begin
            if (int'(node_slot) == s)
            begin
                slot_half = half_vec_reg[s];
            end
        end
    end

    assign node_axis       = (node_slot >= first_count);
    assign node_cat        = node_axis ? second_cat_reg : first_cat_reg;
    assign node_ax_missing = ax_missing_reg[node_axis];
    assign slot_value      = val_in_range_reg ? val_rd_reg : '0;
    assign go_right        = node_cat ? slot_half : !(slot_value <= node_thr);
    assign next_idx        = node_ax_missing ? node_missing : (go_right ? node_right : node_left);
    assign next_in_range   = (32'(next_idx) < NODE_COUNT);

    // ------------------------------------------------------------------
    // Walk sequencer.
    // ------------------------------------------------------------------
    logic [SW-1:0] steps_reg;
    logic [SW-1:0] steps_next;
    logic [7:0]    res_bin_reg;
    logic [7:0]    res_bin_next;
    logic          res_fault_reg;
    logic          res_fault_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    tdtr_pkg::out_item_t out_data_reg;
    tdtr_pkg::out_item_t out_data_next;
    logic          at_cap;

    assign at_cap = (steps_reg == SW'(NODE_COUNT - 1));

    always_comb
    begin
        state_next     = state_reg;
        steps_next     = steps_reg;
        res_bin_next   = res_bin_reg;
        res_fault_next = res_fault_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        node_re        = 1'b0;
        node_raddr     = '0;
        val_rd         = 1'b0;

        unique case (state_reg)
            tdtr_pkg::ST_IDLE:
            begin
                if (route_start)
                begin
                    // Every walk starts at node zero.
                    node_re    = 1'b1;
                    steps_next = '0;
                    state_next = tdtr_pkg::ST_NODE;
                end
            end
            tdtr_pkg::ST_NODE:
            begin
                if (node_leaf)
                begin
                    res_bin_next   = node_bin;
                    res_fault_next = 1'b0;
                    state_next     = tdtr_pkg::ST_DONE;
                end
                else
                begin
                    // Fetch the tested slot's value for the threshold compare.
                    val_rd     = (32'(node_slot) < VALUE_SLOTS);
                    state_next = tdtr_pkg::ST_DECIDE;
                end
            end
            tdtr_pkg::ST_DECIDE:
            begin
                steps_next = steps_reg + SW'(1);
                if (at_cap || !next_in_range)
                begin
                    // Either the step cap was reached or the tree points past
                    // the node memory: the walk ends in a fault.
                    res_bin_next   = 8'd0;
                    res_fault_next = 1'b1;
                    state_next     = tdtr_pkg::ST_DONE;
                end
                else
                begin
                    node_re    = 1'b1;
                    node_raddr = node_addr(next_idx);
                    state_next = tdtr_pkg::ST_NODE;
                end
            end
            tdtr_pkg::ST_DONE:
            begin
                // Wait until the output register is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    out_data_next.bin   = res_bin_reg;
                    out_data_next.fault = res_fault_reg;
                    state_next          = tdtr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdtr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdtr_pkg::ST_IDLE;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result and lookup payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        res_bin_reg   <= res_bin_next;
        res_fault_reg <= res_fault_next;
        out_data_reg  <= out_data_next;
        if (route_start)
        begin
            ax_missing_reg <= {axis1_missing, axis0_missing};
        end
        if (state_reg == tdtr_pkg::ST_NODE)
        begin
            val_in_range_reg <= (32'(node_slot) < VALUE_SLOTS);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
